>>> hdl/gne_pkg.sv
// gne_pkg: shared widths, table sizes, op codes and the pipeline control word
// for the gradient noise evaluator. No dependencies.

package gne_pkg;

  localparam int OP_W       = 3;
  localparam int COORD_W    = 24;
  localparam int INDEX_W    = 9;
  localparam int PERM_W     = 8;
  localparam int GRAD_W     = 16;
  localparam int NOISE_W    = 19;
  localparam int CELL_W     = 8;
  localparam int OUT_FRAC   = 16;

  localparam int PERM_DEPTH = 512;
  localparam int GRAD_DEPTH = 256;
  localparam int PERM_AW    = $clog2(PERM_DEPTH);
  localparam int GRAD_AW    = $clog2(GRAD_DEPTH);

  localparam int NOISE_MAX  = 262143;
  localparam int NOISE_MIN  = -262144;

  localparam logic [OP_W-1:0] OP_EVAL_LINE  = 3'd0;
  localparam logic [OP_W-1:0] OP_EVAL_PLANE = 3'd1;
  localparam logic [OP_W-1:0] OP_LOAD_PERM  = 3'd2;
  localparam logic [OP_W-1:0] OP_LOAD_LINE  = 3'd3;
  localparam logic [OP_W-1:0] OP_LOAD_PLANE = 3'd4;

  typedef struct packed {
    logic            valid;
    logic [OP_W-1:0] op;
  } ctl_t;

endpackage

>>> hdl/gne_if.sv
// gne_if: valid/ready channel interfaces for the noise evaluator's input and
// result words. Depends on gne_pkg for field widths.

interface gne_in_if;
  logic                                valid;
  logic                                ready;
  logic        [gne_pkg::OP_W-1:0]     op;
  logic signed [gne_pkg::COORD_W-1:0]  coord_x;
  logic signed [gne_pkg::COORD_W-1:0]  coord_y;
  logic        [gne_pkg::INDEX_W-1:0]  table_index;
  logic        [gne_pkg::PERM_W-1:0]   perm_value;
  logic signed [gne_pkg::GRAD_W-1:0]   grad_first;
  logic signed [gne_pkg::GRAD_W-1:0]   grad_second;

  modport source (output valid, op, coord_x, coord_y, table_index, perm_value,
                  grad_first, grad_second, input ready);
  modport sink   (input valid, op, coord_x, coord_y, table_index, perm_value,
                  grad_first, grad_second, output ready);
endinterface

interface gne_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [gne_pkg::NOISE_W-1:0]  noise_value;

  modport source (output valid, noise_value, input ready);
  modport sink   (input valid, noise_value, output ready);
endinterface

>>> hdl/gne_ram.sv
// gne_ram: generic single write port, single read port RAM with registered read.
// No dependencies.

module gne_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/gne_mul.sv
// gne_mul: registered signed multiply, scaled down by 2^SH with round to
// nearest, ties away from zero. No dependencies.

module gne_mul #(
  parameter int AW = 16,
  parameter int BW = 16,
  parameter int SH = 16,
  parameter int OW = 16
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  output logic signed [OW-1:0] q
);

  localparam int PW = AW + BW;
  localparam logic signed [PW:0] HALF    = (PW+1)'(1) << (SH - 1);
  localparam logic signed [PW:0] HALF_M1 = HALF - (PW+1)'(1);

  logic signed [PW-1:0] p;
  logic signed [PW:0]   pr;

  always_comb begin
    p  = a * b;
    // negative products take half minus one so the tie goes away from zero
    pr = {p[PW-1], p} + (p[PW-1] ? HALF_M1 : HALF);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= OW'(pr >>> SH);
    end
  end

endmodule

>>> hdl/gne_fade.sv
// gne_fade: three stage quintic fade s = t^3 (t (6t - 15) + 10) in fixed point.
// Depends on gne_mul.

module gne_fade #(
  parameter int F = 16
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [F+1:0] t,
  output logic signed [F+6:0] s
);

  localparam int FW  = F + 2;
  localparam int IW  = F + 6;
  localparam int PLW = F + 7;
  localparam logic signed [IW-1:0]  FIFTEEN = {6'd15, {F{1'b0}}};
  localparam logic signed [PLW-1:0] TEN     = {7'd10, {F{1'b0}}};

  logic signed [IW-1:0]  te;
  logic signed [IW-1:0]  inner;
  logic signed [FW-1:0]  t2;
  logic signed [IW-1:0]  ti;
  logic signed [FW-1:0]  t_d;
  logic signed [FW-1:0]  t3;
  logic signed [PLW-1:0] poly;

  always_comb begin
    te    = IW'(t);
    inner = (te <<< 2) + (te <<< 1) - FIFTEEN;
  end

  gne_mul #(.AW(FW), .BW(FW), .SH(F), .OW(FW)) u_sq (
    .clk(clk), .en(en), .a(t), .b(t), .q(t2)
  );

  gne_mul #(.AW(FW), .BW(IW), .SH(F), .OW(IW)) u_in (
    .clk(clk), .en(en), .a(t), .b(inner), .q(ti)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      t_d  <= t;
      poly <= PLW'(ti) + TEN;
    end
  end

  gne_mul #(.AW(FW), .BW(FW), .SH(F), .OW(FW)) u_cube (
    .clk(clk), .en(en), .a(t2), .b(t_d), .q(t3)
  );

  gne_mul #(.AW(FW), .BW(PLW), .SH(F), .OW(PLW)) u_out (
    .clk(clk), .en(en), .a(t3), .b(poly), .q(s)
  );

endmodule

>>> hdl/gradient_noise_evaluator.sv
// Gradient noise evaluator: 1D/2D lattice gradient noise in fixed point.
// Depends on gne_pkg, gne_if, gne_ram, gne_mul and gne_fade.
//
// Usage:
//   sample: input words. op selects 1D or 2D evaluation, or a load of the
//     permutation table or of the 1D/2D gradient tables at table_index.
//   result: one word per input word. noise_value is the saturated Q3.16 noise
//     for evaluations and zero for loads and unused op codes.
//   Throughput is one word per cycle while result is not stalled. The
//   pipeline depth is set by the table lookup chain (two permutation reads and
//   a gradient read) followed by the dot, two blends and the output
//   scaling.
//   Tables are replicated RAMs so all corner lookups of a step happen at once;
//   a load writes each copy as it passes the stage that reads it, so words
//   see the tables in the order they were taken.
//   Reset clears the pipeline control words and result valid only; table
//   contents stay undefined until loaded. When result is stalled the whole
//   pipeline holds and sample ready drops; nothing is lost or repeated.

module gradient_noise_evaluator #(
  parameter int COORD_FRAC_BITS = 16,
  parameter int GRAD_FRAC_BITS  = 14
) (
  input  logic             clk,
  input  logic             rst,
  gne_in_if.sink           sample,
  gne_out_if.source        result
);

  localparam int F    = COORD_FRAC_BITS;
  localparam int G    = GRAD_FRAC_BITS;
  localparam int FW   = F + 2;
  localparam int SW   = F + 7;
  localparam int TW   = F + 18 - G;
  localparam int DW   = TW + 1;
  localparam int MW1  = DW + 7;
  localparam int BW1  = DW + 8;
  localparam int MW2  = BW1 + 7;
  localparam int VW   = BW1 + 8;
  localparam int OUTW = VW + 18;
  localparam int CW   = gne_pkg::COORD_W;

  localparam logic signed [FW-1:0]   F_ONE = {2'b01, {F{1'b0}}};
  localparam logic signed [VW-1:0]   V_ONE = {{(VW-F-1){1'b0}}, 1'b1, {F{1'b0}}};
  localparam logic signed [OUTW-1:0] O_HALF    = {{(OUTW-F-1){1'b0}}, 1'b1, {F{1'b0}}};
  localparam logic signed [OUTW-1:0] O_HALF_M1 = O_HALF - OUTW'(1);
  localparam logic signed [OUTW-1:0] R_MAX = OUTW'(gne_pkg::NOISE_MAX);
  localparam logic signed [OUTW-1:0] R_MIN = OUTW'(gne_pkg::NOISE_MIN);

  function automatic logic [gne_pkg::CELL_W-1:0] cell_of(input logic signed [CW-1:0] c);
    logic signed [31:0] ce;
    logic signed [31:0] ip;
    logic [F-1:0]       low;
    ce  = 32'(c);
    low = c[F-1:0];
    ip  = ce >>> F;
    // truncation toward zero: negative values with a fraction round up
    if (c[CW-1] && low != '0) begin
      ip = ip + 32'sd1;
    end
    return ip[gne_pkg::CELL_W-1:0];
  endfunction

  function automatic logic signed [FW-1:0] frac_of(input logic signed [CW-1:0] c);
    logic [F-1:0]         low;
    logic signed [FW-1:0] lo_e;
    low  = c[F-1:0];
    lo_e = $signed(FW'(low));
    if (c[CW-1] && low != '0) begin
      return lo_e - F_ONE;
    end
    return lo_e;
  endfunction

  logic en;
  gne_pkg::ctl_t in_ctl;
  gne_pkg::ctl_t ctl [10];

  // stage payloads
  logic [gne_pkg::INDEX_W-1:0] idx1, idx2, idx3;
  logic [gne_pkg::PERM_W-1:0]  pv1, pv2;
  logic signed [gne_pkg::GRAD_W-1:0] gf1, gf2, gf3, gs1, gs2, gs3;
  logic [gne_pkg::CELL_W-1:0]  x0_1, x1_1, y0_1, y0_2, y1_2;
  logic signed [FW-1:0] fx1, fy1, fx2, fy2, fx3, fy3, fx4, fy4, fx3m, fx4m, fy4m;
  logic signed [SW-1:0] sx4, sy4, sx5, sy5, sx6, sy6, sy7, sy8;
  logic signed [TW-1:0] d0_4, d1_4, d0_5, d1_5;
  logic signed [TW-1:0] ax [4];
  logic signed [TW-1:0] ay [4];
  logic signed [FW-1:0] ox [4];
  logic signed [FW-1:0] oy [4];
  logic signed [DW-1:0] dot [4];
  logic signed [DW-1:0] k [4];
  logic signed [DW-1:0] k0_7, k2_7;
  logic signed [DW:0]   diff_lo, diff_hi;
  logic signed [MW1-1:0] m_lo, m_hi;
  logic signed [BW1-1:0] lo8, hi8, lo9;
  logic signed [BW1:0]   diff2;
  logic signed [MW2-1:0] m2;
  logic signed [VW-1:0]  v9, v10;
  logic signed [VW:0]    u10;
  logic signed [OUTW-1:0] pe10, r10;
  logic signed [gne_pkg::NOISE_W-1:0] noise10;

  logic res_valid;
  logic signed [gne_pkg::NOISE_W-1:0] res_noise;

  // table ports
  logic [gne_pkg::PERM_AW-1:0] pa_addr [2];
  logic [gne_pkg::PERM_W-1:0]  px [2];
  logic [gne_pkg::PERM_AW-1:0] pb_addr [4];
  logic [gne_pkg::PERM_W-1:0]  h [4];
  logic [gne_pkg::GRAD_AW-1:0] gl_addr [2];
  logic [gne_pkg::GRAD_W-1:0]  gl [2];
  logic [gne_pkg::GRAD_AW-1:0] gp_addr [4];
  logic [2*gne_pkg::GRAD_W-1:0] gp [4];
  logic we_pa, we_pb, we_gl, we_gp;

  assign en           = !res_valid || result.ready;
  assign sample.ready = en;
  assign result.valid = res_valid;
  assign result.noise_value = res_noise;

  always_comb begin
    in_ctl.valid = sample.valid;
    in_ctl.op    = sample.op;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 10; i++) begin
        ctl[i] <= '0;
      end
      res_valid <= 1'b0;
    end else if (en) begin
      ctl[0] <= in_ctl;
      for (int i = 1; i < 10; i++) begin
        ctl[i] <= ctl[i-1];
      end
      res_valid <= ctl[9].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idx1 <= sample.table_index;
      pv1  <= sample.perm_value;
      gf1  <= sample.grad_first;
      gs1  <= sample.grad_second;
      x0_1 <= cell_of(sample.coord_x);
      y0_1 <= cell_of(sample.coord_y);
      fx1  <= frac_of(sample.coord_x);
      fy1  <= frac_of(sample.coord_y);

      idx2 <= idx1;
      pv2  <= pv1;
      gf2  <= gf1;
      gs2  <= gs1;
      y0_2 <= y0_1;
      fx2  <= fx1;
      fy2  <= fy1;

      idx3 <= idx2;
      gf3  <= gf2;
      gs3  <= gs2;
      fx3  <= fx2;
      fy3  <= fy2;

      fx4  <= fx3;
      fy4  <= fy3;

      sx5  <= sx4;
      sy5  <= sy4;
      d0_5 <= d0_4;
      d1_5 <= d1_4;

      sx6  <= sx5;
      sy6  <= sy5;
      for (int i = 0; i < 4; i++) begin
        k[i] <= dot[i];
      end

      k0_7 <= k[0];
      k2_7 <= k[2];
      sy7  <= sy6;

      lo8  <= BW1'(k0_7) + BW1'(m_lo);
      hi8  <= BW1'(k2_7) + BW1'(m_hi);
      sy8  <= sy7;

      lo9  <= lo8;
      v10  <= v9;

      res_noise <= noise10;
    end
  end

  // first permutation lookup
  assign x1_1       = x0_1 + 8'd1;
  assign pa_addr[0] = gne_pkg::PERM_AW'(x0_1);
  assign pa_addr[1] = gne_pkg::PERM_AW'(x1_1);
  assign we_pa      = en && ctl[0].valid && ctl[0].op == gne_pkg::OP_LOAD_PERM;

  for (genvar i = 0; i < 2; i++) begin : g_perm_a
    gne_ram #(.WIDTH(gne_pkg::PERM_W), .DEPTH(gne_pkg::PERM_DEPTH)) u_ram (
      .clk(clk), .we(we_pa), .waddr(idx1), .wdata(pv1),
      .re(en), .raddr(pa_addr[i]), .rdata(px[i])
    );
  end

  // second permutation lookup and 1D gradients
  assign y1_2       = y0_2 + 8'd1;
  assign pb_addr[0] = gne_pkg::PERM_AW'(px[0]) + gne_pkg::PERM_AW'(y0_2);
  assign pb_addr[1] = gne_pkg::PERM_AW'(px[1]) + gne_pkg::PERM_AW'(y0_2);
  assign pb_addr[2] = gne_pkg::PERM_AW'(px[0]) + gne_pkg::PERM_AW'(y1_2);
  assign pb_addr[3] = gne_pkg::PERM_AW'(px[1]) + gne_pkg::PERM_AW'(y1_2);
  assign we_pb      = en && ctl[1].valid && ctl[1].op == gne_pkg::OP_LOAD_PERM;

  for (genvar i = 0; i < 4; i++) begin : g_perm_b
    gne_ram #(.WIDTH(gne_pkg::PERM_W), .DEPTH(gne_pkg::PERM_DEPTH)) u_ram (
      .clk(clk), .we(we_pb), .waddr(idx2), .wdata(pv2),
      .re(en), .raddr(pb_addr[i]), .rdata(h[i])
    );
  end

  assign gl_addr[0] = gne_pkg::GRAD_AW'(px[0]);
  assign gl_addr[1] = gne_pkg::GRAD_AW'(px[1]);
  assign we_gl = en && ctl[1].valid && ctl[1].op == gne_pkg::OP_LOAD_LINE &&
                 idx2 < gne_pkg::INDEX_W'(gne_pkg::GRAD_DEPTH);

  for (genvar i = 0; i < 2; i++) begin : g_line
    gne_ram #(.WIDTH(gne_pkg::GRAD_W), .DEPTH(gne_pkg::GRAD_DEPTH)) u_ram (
      .clk(clk), .we(we_gl), .waddr(idx2[gne_pkg::GRAD_AW-1:0]), .wdata(gf2),
      .re(en), .raddr(gl_addr[i]), .rdata(gl[i])
    );
  end

  // 2D gradients; h order is (x0,y0) (x1,y0) (x0,y1) (x1,y1)
  assign we_gp = en && ctl[2].valid && ctl[2].op == gne_pkg::OP_LOAD_PLANE &&
                 idx3 < gne_pkg::INDEX_W'(gne_pkg::GRAD_DEPTH);

  for (genvar i = 0; i < 4; i++) begin : g_plane
    assign gp_addr[i] = gne_pkg::GRAD_AW'(h[i]);
    gne_ram #(.WIDTH(2*gne_pkg::GRAD_W), .DEPTH(gne_pkg::GRAD_DEPTH)) u_ram (
      .clk(clk), .we(we_gp), .waddr(idx3[gne_pkg::GRAD_AW-1:0]), .wdata({gs3, gf3}),
      .re(en), .raddr(gp_addr[i]), .rdata(gp[i])
    );
  end

  // fade curves, stage 1 to stage 4
  gne_fade #(.F(F)) u_fade_x (.clk(clk), .en(en), .t(fx1), .s(sx4));
  gne_fade #(.F(F)) u_fade_y (.clk(clk), .en(en), .t(fy1), .s(sy4));

  // 1D dot products
  assign fx3m = fx3 - F_ONE;

  gne_mul #(.AW(FW), .BW(gne_pkg::GRAD_W), .SH(G), .OW(TW)) u_d0 (
    .clk(clk), .en(en), .a(fx3), .b($signed(gl[0])), .q(d0_4)
  );
  gne_mul #(.AW(FW), .BW(gne_pkg::GRAD_W), .SH(G), .OW(TW)) u_d1 (
    .clk(clk), .en(en), .a(fx3m), .b($signed(gl[1])), .q(d1_4)
  );

  // 2D dot products
  assign fx4m  = fx4 - F_ONE;
  assign fy4m  = fy4 - F_ONE;
  assign ox[0] = fx4;
  assign ox[1] = fx4m;
  assign ox[2] = fx4;
  assign ox[3] = fx4m;
  assign oy[0] = fy4;
  assign oy[1] = fy4;
  assign oy[2] = fy4m;
  assign oy[3] = fy4m;

  for (genvar i = 0; i < 4; i++) begin : g_dot
    gne_mul #(.AW(gne_pkg::GRAD_W), .BW(FW), .SH(G), .OW(TW)) u_gx (
      .clk(clk), .en(en), .a($signed(gp[i][gne_pkg::GRAD_W-1:0])), .b(ox[i]), .q(ax[i])
    );
    gne_mul #(.AW(gne_pkg::GRAD_W), .BW(FW), .SH(G), .OW(TW)) u_gy (
      .clk(clk), .en(en), .a($signed(gp[i][2*gne_pkg::GRAD_W-1:gne_pkg::GRAD_W])),
      .b(oy[i]), .q(ay[i])
    );
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      dot[i] = DW'(ax[i]) + DW'(ay[i]);
    end
    // 1D reuses the lower x blend
    if (ctl[4].op == gne_pkg::OP_EVAL_LINE) begin
      dot[0] = DW'(d0_5);
      dot[1] = DW'(d1_5);
    end
  end

  // blend along x
  assign diff_lo = (DW+1)'(k[1]) - (DW+1)'(k[0]);
  assign diff_hi = (DW+1)'(k[3]) - (DW+1)'(k[2]);

  gne_mul #(.AW(DW+1), .BW(SW), .SH(F), .OW(MW1)) u_blend_lo (
    .clk(clk), .en(en), .a(diff_lo), .b(sx6), .q(m_lo)
  );
  gne_mul #(.AW(DW+1), .BW(SW), .SH(F), .OW(MW1)) u_blend_hi (
    .clk(clk), .en(en), .a(diff_hi), .b(sx6), .q(m_hi)
  );

  // blend along y
  assign diff2 = (BW1+1)'(hi8) - (BW1+1)'(lo8);

  gne_mul #(.AW(BW1+1), .BW(SW), .SH(F), .OW(MW2)) u_blend_y (
    .clk(clk), .en(en), .a(diff2), .b(sy8), .q(m2)
  );

  always_comb begin
    if (ctl[8].op == gne_pkg::OP_EVAL_PLANE) begin
      v9 = VW'(lo9) + VW'(m2);
    end else begin
      v9 = VW'(lo9);
    end
  end

  // map (v + 1) / 2 into Q3.16 and saturate
  always_comb begin
    u10  = (VW+1)'(v10) + (VW+1)'(V_ONE);
    pe10 = OUTW'($signed({u10, {gne_pkg::OUT_FRAC{1'b0}}}));
    r10  = (pe10 + (pe10[OUTW-1] ? O_HALF_M1 : O_HALF)) >>> (F + 1);
    priority if (ctl[9].op != gne_pkg::OP_EVAL_LINE &&
                 ctl[9].op != gne_pkg::OP_EVAL_PLANE) begin
      noise10 = '0;
    end else if (r10 > R_MAX) begin
      noise10 = gne_pkg::NOISE_W'(R_MAX);
    end else if (r10 < R_MIN) begin
      noise10 = gne_pkg::NOISE_W'(R_MIN);
    end else begin
      noise10 = gne_pkg::NOISE_W'(r10);
    end
  end

endmodule
